// ----- src/npi_pkg.sv -----
// Package for the Neville polynomial interpolator.
// Holds fixed-point types, codes, controller/datapath structs and saturating helpers.
// No dependencies.
package npi_pkg;

  localparam int DEFAULT_MAX_POINTS = 16;
  localparam int PU_W = 5;
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;

  localparam logic [PU_W-1:0] POINTS_USED_RESET = 5'd4;
  localparam logic [APB_AW-1:0] REG_POINTS_USED = 2'd0;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_COINCIDENT = 2'd2;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic load;
    logic start_q;
    logic scan_cap;
    logic y0_rd;
    logic y0_cap;
    logic a_cap;
    logic b_cap;
    logic div_go;
    logic mul_go;
    logic mul_upper;
    logic wr_d;
    logic wr_c;
    logic next_i;
    logic dy_rd;
    logic dy_cap;
    logic out_load;
    logic [1:0] out_code;
  } npi_cmd_t;

  typedef struct packed {
    logic short_window;
    logic scan_last;
    logic mm_one;
    logic den_zero;
    logic div_done;
    logic mul_done;
    logic i_last;
    logic m_last;
    logic out_free;
  } npi_sts_t;

  function automatic logic [63:0] fx_mag(fx_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic fx_t from_mag(logic neg, logic [63:0] m);
    if (!neg) begin
      return m[63] ? FX_MAX : fx_t'(m);
    end
    return m[63] ? FX_MIN : fx_t'(-m);
  endfunction

  function automatic fx_t sat_add(fx_t a, fx_t b);
    fx_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? FX_MIN : FX_MAX;
    end
    return s;
  endfunction

  function automatic fx_t sat_sub(fx_t a, fx_t b);
    fx_t s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      return a[63] ? FX_MIN : FX_MAX;
    end
    return s;
  endfunction

endpackage

// ----- src/npi_in_if.sv -----
// Request channel of the Neville polynomial interpolator.
// Carries load and query requests; depends on nothing.
interface npi_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [3:0] sample_index;
  logic signed [63:0] sample_x;
  logic signed [63:0] sample_y;
  logic signed [63:0] query_x;
  logic [3:0] window_start;

  modport source (output valid, cmd, sample_index, sample_x, sample_y, query_x, window_start,
                  input ready);
  modport sink (input valid, cmd, sample_index, sample_x, sample_y, query_x, window_start,
                output ready);
endinterface

// ----- src/npi_out_if.sv -----
// Result channel of the Neville polynomial interpolator.
// Carries value, error estimate and status; depends on nothing.
interface npi_out_if;
  logic valid;
  logic ready;
  logic signed [63:0] value;
  logic signed [63:0] error_estimate;
  logic [1:0] status;

  modport source (output valid, value, error_estimate, status, input ready);
  modport sink (input valid, value, error_estimate, status, output ready);
endinterface

// ----- src/npi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/npi_div.sv -----
// Iterative signed Q31.32 divider, one quotient bit per cycle, saturating.
// Depends on npi_pkg.
module npi_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  npi_pkg::fx_t  num,
  input  npi_pkg::fx_t  den,
  output logic          done,
  output npi_pkg::fx_t  quot
);

  logic        busy;
  logic        iter;
  logic [5:0]  cnt;
  logic [63:0] a;
  logic [63:0] b;
  logic        neg;
  logic [63:0] rem;
  logic [63:0] sh;
  logic [63:0] qb;
  logic [65:0] trial;
  logic        ge;

  assign trial = {1'b0, rem, sh[63]} - {2'b00, b};
  assign ge = !trial[65];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= 1'b0;
        a <= npi_pkg::fx_mag(num);
        b <= npi_pkg::fx_mag(den);
        neg <= num[63] ^ den[63];
      end else if (busy && !iter) begin
        if ({32'b0, a} >= {b, 32'b0}) begin
          quot <= neg ? npi_pkg::FX_MIN : npi_pkg::FX_MAX;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem <= {32'b0, a[63:32]};
          sh <= {a[31:0], 32'b0};
          qb <= '0;
          cnt <= '0;
          iter <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? trial[63:0] : {rem[62:0], sh[63]};
        sh <= {sh[62:0], 1'b0};
        qb <= {qb[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          quot <= npi_pkg::from_mag(neg, {qb[62:0], ge});
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/npi_mul.sv -----
// Signed Q31.32 multiplier built from four 32x32 partial products, saturating.
// Depends on npi_pkg.
module npi_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  npi_pkg::fx_t  a,
  input  npi_pkg::fx_t  b,
  output logic          done,
  output npi_pkg::fx_t  prod
);

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [63:0]  pp;
  logic [1:0]   pk;
  logic [127:0] acc;
  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [127:0] addend;
  logic [127:0] acc_sum;

  assign opa = cnt[1] ? ma[63:32] : ma[31:0];
  assign opb = cnt[0] ? mb[63:32] : mb[31:0];

  always_comb begin
    case (pk)
      2'd0: addend = {64'b0, pp};
      2'd3: addend = {pp, 64'b0};
      default: addend = {32'b0, pp, 32'b0};
    endcase
  end

  assign acc_sum = acc + addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        ma <= npi_pkg::fx_mag(a);
        mb <= npi_pkg::fx_mag(b);
        neg <= a[63] ^ b[63];
        acc <= '0;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          pp <= opa * opb;
          pk <= cnt[1:0];
        end
        if (cnt != 3'd0) begin
          acc <= acc_sum;
        end
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (acc_sum[127:96] != 32'b0) begin
            prod <= neg ? npi_pkg::FX_MIN : npi_pkg::FX_MAX;
          end else begin
            prod <= npi_pkg::from_mag(neg, acc_sum[95:32]);
          end
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule

// ----- src/npi_datapath.sv -----
// Datapath: sample stores, tableau correction rows, divider, multiplier, result register.
// Depends on npi_pkg, npi_ram, npi_div and npi_mul.
module npi_datapath #(
  parameter int MAX_POINTS = npi_pkg::DEFAULT_MAX_POINTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  npi_pkg::npi_cmd_t            cmd,
  output npi_pkg::npi_sts_t            sts,
  input  logic [npi_pkg::PU_W-1:0]     points_used,
  input  logic [3:0]                   sample_index,
  input  npi_pkg::fx_t                 sample_x,
  input  npi_pkg::fx_t                 sample_y,
  input  npi_pkg::fx_t                 query_x,
  input  logic [3:0]                   window_start,
  output logic                         res_valid,
  input  logic                         res_ready,
  output npi_pkg::fx_t                 value,
  output npi_pkg::fx_t                 error_estimate,
  output logic [1:0]                   status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = (CW > npi_pkg::PU_W) ? CW : npi_pkg::PU_W;
  localparam int SW = ((CW > 4) ? CW : 4) + 1;
  localparam int NW = AW + 1;
  localparam int TW = AW + 3;

  logic [CW-1:0]        count;
  logic [CW-1:0]        mm;
  logic [CW-1:0]        mm_next;
  logic [CW-1:0]        idx_p1;
  logic                 load_ok;
  npi_pkg::fx_t         qx;
  logic [3:0]           ws;
  logic [AW-1:0]        base;
  logic [AW-1:0]        i;
  logic [AW-1:0]        m;
  logic signed [NW-1:0] ns;
  logic [NW-1:0]        ns_p1;
  logic [63:0]          best;
  logic [63:0]          x_gap;
  npi_pkg::fx_t         y;
  npi_pkg::fx_t         dy;
  npi_pkg::fx_t         dv;
  npi_pkg::fx_t         xi;
  npi_pkg::fx_t         w;
  npi_pkg::fx_t         ho;
  npi_pkg::fx_t         hp;
  npi_pkg::fx_t         den;
  logic                 up_sel;
  logic                 up;
  logic [TW-1:0]        lhs;
  logic [TW-1:0]        rhs;
  logic [PW-1:0]        pu_w;

  logic [AW-1:0]        x_raddr;
  logic [AW-1:0]        y_raddr;
  logic [AW-1:0]        c_raddr;
  logic [AW-1:0]        d_raddr;
  npi_pkg::fx_t         x_rdata;
  npi_pkg::fx_t         y_rdata;
  npi_pkg::fx_t         c_rdata;
  npi_pkg::fx_t         d_rdata;
  logic                 c_we;
  logic                 d_we;
  npi_pkg::fx_t         c_wdata;
  npi_pkg::fx_t         d_wdata;
  npi_pkg::fx_t         quot;
  npi_pkg::fx_t         prod;
  logic                 div_done;
  logic                 mul_done;

  assign pu_w = PW'(points_used);

  always_comb begin
    if (pu_w == '0) begin
      mm_next = CW'(1);
    end else if (pu_w > PW'(MAX_POINTS)) begin
      mm_next = CW'(MAX_POINTS);
    end else begin
      mm_next = CW'(pu_w);
    end
  end

  assign load_ok = cmd.load && (int'(sample_index) < MAX_POINTS);
  assign idx_p1 = CW'(sample_index) + CW'(1);

  assign x_gap = (qx >= x_rdata) ? $unsigned(qx - x_rdata) : $unsigned(x_rdata - qx);

  assign ns_p1 = $unsigned(ns) + NW'(1);
  assign lhs = TW'({ns_p1, 1'b0});
  assign rhs = TW'(mm) - TW'(m);
  assign up = lhs < rhs;
  assign dv = up_sel ? c_rdata : d_rdata;

  assign x_raddr = cmd.a_cap ? base + i + m : base + i;
  assign y_raddr = cmd.y0_rd ? base + ns[AW-1:0] : base + i;
  assign c_raddr = cmd.dy_rd ? ns_p1[AW-1:0] : i + AW'(1);
  assign d_raddr = cmd.dy_rd ? (ns[NW-1] ? '0 : ns[AW-1:0]) : i;

  assign c_we = cmd.scan_cap || cmd.wr_c;
  assign d_we = cmd.scan_cap || cmd.wr_d;
  assign c_wdata = cmd.scan_cap ? y_rdata : prod;
  assign d_wdata = cmd.scan_cap ? y_rdata : prod;

  assign sts.short_window = (SW'(ws) + SW'(mm)) > SW'(count);
  assign sts.scan_last = CW'(i) == mm - CW'(1);
  assign sts.mm_one = mm == CW'(1);
  assign sts.den_zero = den == '0;
  assign sts.div_done = div_done;
  assign sts.mul_done = mul_done;
  assign sts.i_last = CW'(i) == mm - CW'(m) - CW'(1);
  assign sts.m_last = CW'(m) == mm - CW'(1);
  assign sts.out_free = !res_valid || res_ready;

  npi_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_xram (
    .clk(clk), .we(load_ok), .waddr(AW'(sample_index)), .wdata(sample_x),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  npi_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_yram (
    .clk(clk), .we(load_ok), .waddr(AW'(sample_index)), .wdata(sample_y),
    .raddr(y_raddr), .rdata(y_rdata)
  );

  npi_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_cram (
    .clk(clk), .we(c_we), .waddr(i), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  npi_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_dram (
    .clk(clk), .we(d_we), .waddr(i), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  npi_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_go), .num(w), .den(den),
    .done(div_done), .quot(quot)
  );

  npi_mul u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_go), .a(cmd.mul_upper ? ho : hp), .b(quot),
    .done(mul_done), .prod(prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load_ok && idx_p1 > count) begin
        count <= idx_p1;
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_code;
      value <= (cmd.out_code == npi_pkg::ST_OK) ? y : '0;
      error_estimate <= (cmd.out_code == npi_pkg::ST_OK) ? dy : '0;
    end
    if (cmd.start_q) begin
      qx <= query_x;
      ws <= window_start;
      base <= AW'(window_start);
      mm <= mm_next;
      i <= '0;
    end
    if (cmd.scan_cap) begin
      if (i == '0 || x_gap < best) begin
        best <= x_gap;
        ns <= signed'({1'b0, i});
      end
      i <= i + AW'(1);
    end
    if (cmd.y0_cap) begin
      y <= y_rdata;
      dy <= '0;
      ns <= ns - NW'(1);
      i <= '0;
      m <= AW'(1);
    end
    if (cmd.a_cap) begin
      xi <= x_rdata;
      w <= npi_pkg::sat_sub(c_rdata, d_rdata);
    end
    if (cmd.b_cap) begin
      ho <= npi_pkg::sat_sub(xi, qx);
      hp <= npi_pkg::sat_sub(x_rdata, qx);
      den <= npi_pkg::sat_sub(xi, x_rdata);
    end
    if (cmd.next_i) begin
      i <= i + AW'(1);
    end
    if (cmd.dy_rd) begin
      up_sel <= up;
    end
    if (cmd.dy_cap) begin
      dy <= dv;
      y <= npi_pkg::sat_add(y, dv);
      if (!up_sel) begin
        ns <= ns - NW'(1);
      end
      m <= m + AW'(1);
      i <= '0;
    end
  end

endmodule

// ----- src/npi_ctrl.sv -----
// Controller state machine sequencing load, window scan and Neville tableau steps.
// Depends on npi_pkg.
module npi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  output npi_pkg::npi_cmd_t  cmd,
  input  npi_pkg::npi_sts_t  sts
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_CHECK      = 5'd1;
  localparam logic [4:0] S_SCAN_RD    = 5'd2;
  localparam logic [4:0] S_SCAN_CAP   = 5'd3;
  localparam logic [4:0] S_Y0_RD      = 5'd4;
  localparam logic [4:0] S_Y0_CAP     = 5'd5;
  localparam logic [4:0] S_A_RD       = 5'd6;
  localparam logic [4:0] S_A_CAP      = 5'd7;
  localparam logic [4:0] S_B_CAP      = 5'd8;
  localparam logic [4:0] S_DEN_CHK    = 5'd9;
  localparam logic [4:0] S_DIV_WAIT   = 5'd10;
  localparam logic [4:0] S_MUL_D      = 5'd11;
  localparam logic [4:0] S_MUL_D_WAIT = 5'd12;
  localparam logic [4:0] S_MUL_C      = 5'd13;
  localparam logic [4:0] S_MUL_C_WAIT = 5'd14;
  localparam logic [4:0] S_DY_RD      = 5'd15;
  localparam logic [4:0] S_DY_CAP     = 5'd16;
  localparam logic [4:0] S_FINISH     = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] code;
  logic [1:0] code_next;

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    state_next = state;
    code_next = code;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == npi_pkg::CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start_q = 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.short_window) begin
          code_next = npi_pkg::ST_SHORT;
          state_next = S_FINISH;
        end else begin
          code_next = npi_pkg::ST_OK;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CAP;
      S_SCAN_CAP: begin
        cmd.scan_cap = 1'b1;
        state_next = sts.scan_last ? S_Y0_RD : S_SCAN_RD;
      end
      S_Y0_RD: begin
        cmd.y0_rd = 1'b1;
        state_next = S_Y0_CAP;
      end
      S_Y0_CAP: begin
        cmd.y0_cap = 1'b1;
        state_next = sts.mm_one ? S_FINISH : S_A_RD;
      end
      S_A_RD: state_next = S_A_CAP;
      S_A_CAP: begin
        cmd.a_cap = 1'b1;
        state_next = S_B_CAP;
      end
      S_B_CAP: begin
        cmd.b_cap = 1'b1;
        state_next = S_DEN_CHK;
      end
      S_DEN_CHK: begin
        if (sts.den_zero) begin
          code_next = npi_pkg::ST_COINCIDENT;
          state_next = S_FINISH;
        end else begin
          cmd.div_go = 1'b1;
          state_next = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = S_MUL_D;
        end
      end
      S_MUL_D: begin
        cmd.mul_go = 1'b1;
        state_next = S_MUL_D_WAIT;
      end
      S_MUL_D_WAIT: begin
        if (sts.mul_done) begin
          cmd.wr_d = 1'b1;
          state_next = S_MUL_C;
        end
      end
      S_MUL_C: begin
        cmd.mul_go = 1'b1;
        cmd.mul_upper = 1'b1;
        state_next = S_MUL_C_WAIT;
      end
      S_MUL_C_WAIT: begin
        if (sts.mul_done) begin
          cmd.wr_c = 1'b1;
          if (sts.i_last) begin
            state_next = S_DY_RD;
          end else begin
            cmd.next_i = 1'b1;
            state_next = S_A_RD;
          end
        end
      end
      S_DY_RD: begin
        cmd.dy_rd = 1'b1;
        state_next = S_DY_CAP;
      end
      S_DY_CAP: begin
        cmd.dy_cap = 1'b1;
        state_next = sts.m_last ? S_FINISH : S_A_RD;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.out_code = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code <= npi_pkg::ST_OK;
    end else begin
      state <= state_next;
      code <= code_next;
    end
  end

`ifndef SYNTH
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while the output register is still occupied");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> !sts.den_zero)
    else $error("divider started with a zero divisor");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> (state == S_MUL_D_WAIT || state == S_MUL_C_WAIT))
    else $error("multiplier finished outside its wait states");
`endif

endmodule

// ----- src/neville_polynomial_interpolator.sv -----
// Neville polynomial interpolator in signed Q31.32. A load request (cmd 0) writes one
// sample pair without leaving the idle state. A query request (cmd 1) interpolates at
// query_x over points_used samples (clamped to 1..MAX_POINTS) from window_start: a
// window check, a scan for the nearest sample and the first ordinate, then one pass of
// the shared iterative divider and two of the shared multiplier for each of the
// n*(n-1)/2 tableau entries, and a correction step per tableau column. One query runs
// at a time; the result register frees the request side.
module neville_polynomial_interpolator #(
  parameter int MAX_POINTS = npi_pkg::DEFAULT_MAX_POINTS
) (
  input  logic                        clk,
  input  logic                        rst,
  npi_in_if.sink                      req,
  npi_out_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [npi_pkg::APB_AW-1:0]  paddr,
  input  logic [npi_pkg::APB_DW-1:0]  pwdata,
  output logic [npi_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic [npi_pkg::PU_W-1:0] points_used;
  npi_pkg::npi_cmd_t        cmd;
  npi_pkg::npi_sts_t        sts;

  assign pready = 1'b1;
  assign prdata = (paddr == npi_pkg::REG_POINTS_USED) ?
                  npi_pkg::APB_DW'(points_used) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_used <= npi_pkg::POINTS_USED_RESET;
    end else if (psel && penable && pwrite && paddr == npi_pkg::REG_POINTS_USED) begin
      points_used <= pwdata[npi_pkg::PU_W-1:0];
    end
  end

  npi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_cmd(req.cmd), .in_ready(req.ready),
    .cmd(cmd), .sts(sts)
  );

  npi_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .points_used(points_used),
    .sample_index(req.sample_index), .sample_x(req.sample_x), .sample_y(req.sample_y),
    .query_x(req.query_x), .window_start(req.window_start),
    .res_valid(res.valid), .res_ready(res.ready), .value(res.value),
    .error_estimate(res.error_estimate), .status(res.status)
  );

endmodule

// ----- bench/neville_polynomial_interpolator_tb.sv -----
// Self-checking testbench for the Neville polynomial interpolator.
// Drives load and query requests, predicts every result and compares it field by field.
// Depends on npi_pkg, npi_in_if, npi_out_if and the interpolator top level.
`timescale 1ns / 100ps

module neville_polynomial_interpolator_tb;

  localparam int NPTS = 16;
  localparam int STALL_LIMIT = 60000;

  typedef struct {
    logic cmd;
    logic [3:0] idx;
    npi_pkg::fx_t sx;
    npi_pkg::fx_t sy;
    npi_pkg::fx_t qx;
    logic [3:0] ws;
  } request_t;

  typedef struct {
    npi_pkg::fx_t value;
    npi_pkg::fx_t err;
    logic [1:0] status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [npi_pkg::APB_AW-1:0] paddr = '0;
  logic [npi_pkg::APB_DW-1:0] pwdata = '0;
  logic [npi_pkg::APB_DW-1:0] prdata;
  logic pready;

  npi_in_if req_if();
  npi_out_if res_if();

  neville_polynomial_interpolator dut (
    .clk(clk), .rst(rst), .req(req_if), .res(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  request_t pending_requests[$];
  answer_t expected_answers[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  npi_pkg::fx_t xs[NPTS] = '{default: '0};
  npi_pkg::fx_t ys[NPTS] = '{default: '0};
  bit written[NPTS];
  int sample_count = 0;
  int points_cfg = 4;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic npi_pkg::fx_t mag_to_fx(logic neg, logic [63:0] m);
    if (!neg) return m[63] ? npi_pkg::FX_MAX : npi_pkg::fx_t'(m);
    return m[63] ? npi_pkg::FX_MIN : npi_pkg::fx_t'(-m);
  endfunction

  function automatic logic [63:0] abs_fx(npi_pkg::fx_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic npi_pkg::fx_t add_clamp(npi_pkg::fx_t a, npi_pkg::fx_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(npi_pkg::FX_MAX)) return npi_pkg::FX_MAX;
    if (s < 65'(npi_pkg::FX_MIN)) return npi_pkg::FX_MIN;
    return s[63:0];
  endfunction

  function automatic npi_pkg::fx_t sub_clamp(npi_pkg::fx_t a, npi_pkg::fx_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(npi_pkg::FX_MAX)) return npi_pkg::FX_MAX;
    if (s < 65'(npi_pkg::FX_MIN)) return npi_pkg::FX_MIN;
    return s[63:0];
  endfunction

  function automatic npi_pkg::fx_t mul_q32(npi_pkg::fx_t a, npi_pkg::fx_t b);
    logic [127:0] p;
    logic neg;
    p = 128'(abs_fx(a)) * 128'(abs_fx(b));
    neg = a[63] ^ b[63];
    if (p[127:96] != 0) return neg ? npi_pkg::FX_MIN : npi_pkg::FX_MAX;
    return mag_to_fx(neg, p[95:32]);
  endfunction

  function automatic npi_pkg::fx_t div_q32(npi_pkg::fx_t w, npi_pkg::fx_t den);
    logic [95:0] q;
    logic neg;
    q = {abs_fx(w), 32'd0} / 96'(abs_fx(den));
    neg = w[63] ^ den[63];
    if (q[95:64] != 0) return neg ? npi_pkg::FX_MIN : npi_pkg::FX_MAX;
    return mag_to_fx(neg, q[63:0]);
  endfunction

  function automatic int window_points();
    if (points_cfg < 1) return 1;
    if (points_cfg > NPTS) return NPTS;
    return points_cfg;
  endfunction

  task automatic interpolate(request_t r);
    npi_pkg::fx_t upper[NPTS];
    npi_pkg::fx_t lower[NPTS];
    npi_pkg::fx_t yv, dy, ho, hp, w, den, q;
    logic [63:0] best, x_gap;
    int mm, ns;
    answer_t a;
    mm = window_points();
    a.value = '0;
    a.err = '0;
    a.status = npi_pkg::ST_SHORT;
    if (int'(r.ws) + mm > sample_count) begin
      expected_answers.push_back(a);
      return;
    end
    ns = 0;
    dy = '0;
    best = (r.qx >= xs[r.ws]) ? 64'(r.qx - xs[r.ws]) : 64'(xs[r.ws] - r.qx);
    for (int i = 0; i < mm; i++) begin
      x_gap = (r.qx >= xs[r.ws+i]) ? 64'(r.qx - xs[r.ws+i]) : 64'(xs[r.ws+i] - r.qx);
      if (x_gap < best) begin
        best = x_gap;
        ns = i;
      end
      upper[i] = ys[r.ws+i];
      lower[i] = ys[r.ws+i];
    end
    yv = ys[r.ws+ns];
    ns--;
    for (int m = 1; m < mm; m++) begin
      for (int i = 0; i < mm - m; i++) begin
        ho = sub_clamp(xs[r.ws+i], r.qx);
        hp = sub_clamp(xs[r.ws+i+m], r.qx);
        w = sub_clamp(upper[i+1], lower[i]);
        den = sub_clamp(xs[r.ws+i], xs[r.ws+i+m]);
        if (den == 0) begin
          a.status = npi_pkg::ST_COINCIDENT;
          expected_answers.push_back(a);
          return;
        end
        q = div_q32(w, den);
        lower[i] = mul_q32(hp, q);
        upper[i] = mul_q32(ho, q);
      end
      if (2 * (ns + 1) < mm - m) begin
        dy = upper[ns+1];
      end else begin
        dy = lower[ns < 0 ? 0 : ns];
        ns--;
      end
      yv = add_clamp(yv, dy);
    end
    a.value = yv;
    a.err = dy;
    a.status = npi_pkg::ST_OK;
    expected_answers.push_back(a);
  endtask

  task automatic submit(request_t r);
    if (r.cmd == npi_pkg::CMD_LOAD) begin
      xs[r.idx] = r.sx;
      ys[r.idx] = r.sy;
      written[r.idx] = 1'b1;
      if (int'(r.idx) + 1 > sample_count) sample_count = int'(r.idx) + 1;
    end else begin
      interpolate(r);
    end
    pending_requests.push_back(r);
  endtask

  function automatic bit window_safe(int ws, int mm);
    if (ws + mm > sample_count) return 1'b1;
    for (int i = ws; i < ws + mm; i++) if (!written[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic npi_pkg::fx_t rand_fx();
    return {$urandom, $urandom};
  endfunction

  task automatic load(int idx, npi_pkg::fx_t x, npi_pkg::fx_t y);
    request_t r;
    r = '{npi_pkg::CMD_LOAD, 4'(idx), x, y, rand_fx(), 4'($urandom_range(15))};
    submit(r);
  endtask

  task automatic query(int ws, npi_pkg::fx_t x);
    request_t r;
    r = '{npi_pkg::CMD_QUERY, 4'($urandom_range(15)), rand_fx(), rand_fx(), x, 4'(ws)};
    submit(r);
  endtask

  task automatic random_request();
    int idx, ws, mm, k, tries;
    npi_pkg::fx_t x, y;
    mm = window_points();
    if ($urandom_range(99) < 55) begin
      tries = 0;
      ws = $urandom_range(15);
      if ($urandom_range(99) < 80) begin
        while (tries < 20 && !(ws + mm <= sample_count && window_safe(ws, mm))) begin
          ws = $urandom_range(15);
          tries++;
        end
      end
      if (window_safe(ws, mm)) begin
        k = $urandom_range(99);
        if (k < 10) x = rand_fx();
        else if (k < 20) x = xs[$urandom_range(15)];
        else x = (npi_pkg::fx_t'($signed($urandom_range(54))) - 24) <<< 32
                 | npi_pkg::fx_t'($urandom);
        query(ws, x);
        return;
      end
    end
    idx = $urandom_range(15);
    k = $urandom_range(99);
    if (k < 10) x = rand_fx();
    else if (k < 15) x = xs[$urandom_range(15)];
    else x = ((npi_pkg::fx_t'(idx) * 3 - 20) <<< 32)
             + npi_pkg::fx_t'($urandom_range(32'h7fff_ffff));
    if ($urandom_range(99) < 10) y = rand_fx();
    else y = npi_pkg::fx_t'($signed({$urandom, $urandom})) >>> 22;
    load(idx, x, y);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || req_if.valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_points_used(int v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= npi_pkg::REG_POINTS_USED;
    pwdata <= npi_pkg::APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    points_cfg = v & 5'h1f;
  endtask

  task automatic report_mismatch(string field, npi_pkg::fx_t got, npi_pkg::fx_t want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.cmd <= npi_pkg::CMD_LOAD;
      req_if.sample_index <= '0;
      req_if.sample_x <= '0;
      req_if.sample_y <= '0;
      req_if.query_x <= '0;
      req_if.window_start <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.cmd <= pending_requests[0].cmd;
        req_if.sample_index <= pending_requests[0].idx;
        req_if.sample_x <= pending_requests[0].sx;
        req_if.sample_y <= pending_requests[0].sy;
        req_if.query_x <= pending_requests[0].qx;
        req_if.window_start <= pending_requests[0].ws;
        void'(pending_requests.pop_front());
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (res_if.valid && res_if.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result", res_if.value, '0);
        end else begin
          want = expected_answers.pop_front();
          if (res_if.status !== want.status)
            report_mismatch("status", npi_pkg::fx_t'(res_if.status),
                            npi_pkg::fx_t'(want.status));
          if (res_if.value !== want.value) report_mismatch("value", res_if.value, want.value);
          if (res_if.error_estimate !== want.err)
            report_mismatch("error_estimate", res_if.error_estimate, want.err);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
        || psel || pending_requests.size() == 0 && expected_answers.size() == 0) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int cfg_values[10] = '{4, 1, 16, 3, 0, 31, 2, 5, 8, 6};
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_points_used(4);
    query(0, '0);
    for (int i = 0; i < 5; i++)
      load(i, npi_pkg::fx_t'(i) <<< 32, (i % 2) ? npi_pkg::FX_MAX : npi_pkg::FX_MIN);
    load(5, 64'sh0000_0003_8000_0000, 64'sh0000_0001_0000_0000);
    query(0, 64'sh0000_0001_8000_0000);
    query(1, npi_pkg::fx_t'(2) <<< 32);
    query(0, npi_pkg::FX_MAX);
    query(1, npi_pkg::FX_MIN);
    query(2, 64'sh0000_0004_0000_0000);
    query(3, '0);
    load(5, npi_pkg::fx_t'(4) <<< 32, '0);
    query(2, '0);
    query(12, '0);
    load(15, npi_pkg::FX_MIN, npi_pkg::FX_MAX);
    load(14, npi_pkg::FX_MAX, npi_pkg::FX_MIN);
    query(13, '0);
    for (int p = 0; p < 10; p++) begin
      wait_idle();
      send_idle_pct = (p < 4) ? 25 : (p < 7) ? 56 : 0;
      recv_stall_pct = (p < 4) ? 56 : (p < 7) ? 25 : 0;
      write_points_used(cfg_values[p]);
      n = (window_points() >= 8) ? 30 : 130;
      for (int k = 0; k < n; k++) begin
        if (p == 1 && k == n / 2) wait_idle();
        random_request();
      end
    end
    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
